// ===== design/fccp_pkg.sv =====
// fccp_pkg: widths, types and helper functions for the filled-contour cell polygon unit
// no dependencies; used by the channel interfaces, the divider and the top level
package fccp_pkg;

   localparam int ZW    = 32;  // field values and vertex coordinates, q16.16
   localparam int DW    = 33;  // exact difference of two fields
   localparam int CFGW  = 31;  // spacing and margin registers
   localparam int COLW  = 10;  // cell column and row
   localparam int GW    = 42;  // grid position, unsigned
   localparam int VW    = 44;  // vertex coordinate before saturation
   localparam int QW    = 31;  // crossing offset, also divider steps
   localparam int PW    = 63;  // dividend: |d| times spacing
   localparam int NVERT = 6;
   localparam int CNTW  = 3;
   localparam int NCAND = 8;   // each corner and each edge crossing
   localparam int SELW  = 3;
   localparam int CSRW  = 2;

   localparam logic [CSRW-1:0] CSR_CELL_WIDTH  = 2'd0;
   localparam logic [CSRW-1:0] CSR_CELL_HEIGHT = 2'd1;
   localparam logic [CSRW-1:0] CSR_EDGE_MARGIN = 2'd2;

   localparam logic [CFGW-1:0] CELL_WIDTH_RESET  = 31'd65536;
   localparam logic [CFGW-1:0] CELL_HEIGHT_RESET = 31'd65536;
   localparam logic [CFGW-1:0] EDGE_MARGIN_RESET = 31'd66;

   typedef struct packed {
      logic       is_cross;
      logic [1:0] corner;
   } vert_ref_type;

   typedef struct packed {
      vert_ref_type [NVERT-1:0] vert;
      logic [CNTW-1:0]          count;
   } plan_type;

   function automatic vert_ref_type mk_ref(input logic is_cross, input logic [1:0] corner);
      vert_ref_type r;
      r.is_cross = is_cross;
      r.corner   = corner;
      return r;
   endfunction

   function automatic logic signed [ZW-1:0] sat32(input logic signed [VW-1:0] v);
      logic signed [ZW-1:0] r;
      if (v[VW-1:ZW-1] == '0 || v[VW-1:ZW-1] == '1) begin
         r = v[ZW-1:0];
      end else if (v[VW-1]) begin
         r = {1'b1, {(ZW-1){1'b0}}};
      end else begin
         r = {1'b0, {(ZW-1){1'b1}}};
      end
      return r;
   endfunction

   // walk round the cell from the highest-numbered corner at or above the level
   function automatic plan_type build_plan(input logic [3:0] ge, input logic [3:0] pos,
                                           input logic keep);
      plan_type p;
      logic [1:0] s1;
      logic [1:0] s2;
      logic [1:0] s3;
      logic [1:0] s4;
      logic found;
      logic [CNTW-1:0] n;
      p = '0;
      s1 = '0;
      found = 1'b0;
      n = '0;
      for (int k = 0; k < 4; k++) begin
         if (ge[k]) begin
            s1 = 2'(k);
            found = 1'b1;
         end
      end
      s2 = s1 + 2'd1;
      s3 = s2 + 2'd1;
      s4 = s3 + 2'd1;
      p.vert[n] = mk_ref(1'b0, s1); n = n + CNTW'(1);
      if (pos[s2]) begin
         p.vert[n] = mk_ref(1'b0, s2); n = n + CNTW'(1);
         if (pos[s3]) begin
            p.vert[n] = mk_ref(1'b0, s3); n = n + CNTW'(1);
            if (pos[s4]) begin
               p.vert[n] = mk_ref(1'b0, s4); n = n + CNTW'(1);
            end else begin
               p.vert[n] = mk_ref(1'b1, s3); n = n + CNTW'(1);
               p.vert[n] = mk_ref(1'b1, s4); n = n + CNTW'(1);
            end
         end else begin
            p.vert[n] = mk_ref(1'b1, s2); n = n + CNTW'(1);
            if (pos[s4]) begin
               p.vert[n] = mk_ref(1'b1, s3); n = n + CNTW'(1);
               p.vert[n] = mk_ref(1'b0, s4); n = n + CNTW'(1);
            end else begin
               p.vert[n] = mk_ref(1'b1, s4); n = n + CNTW'(1);
            end
         end
      end else begin
         p.vert[n] = mk_ref(1'b1, s1); n = n + CNTW'(1);
         if (pos[s3]) begin
            p.vert[n] = mk_ref(1'b1, s2); n = n + CNTW'(1);
            p.vert[n] = mk_ref(1'b0, s3); n = n + CNTW'(1);
            if (pos[s4]) begin
               p.vert[n] = mk_ref(1'b0, s4); n = n + CNTW'(1);
            end else begin
               p.vert[n] = mk_ref(1'b1, s3); n = n + CNTW'(1);
               p.vert[n] = mk_ref(1'b1, s4); n = n + CNTW'(1);
            end
         end else begin
            if (pos[s4]) begin
               p.vert[n] = mk_ref(1'b1, s3); n = n + CNTW'(1);
               p.vert[n] = mk_ref(1'b0, s4); n = n + CNTW'(1);
            end else begin
               p.vert[n] = mk_ref(1'b1, s4); n = n + CNTW'(1);
            end
         end
      end
      p.count = (keep && found) ? n : '0;
      return p;
   endfunction

endpackage

// ===== design/fccp_channels.sv =====
// fccp_req_if and fccp_rsp_if: valid/ready channels for cells and polygon vertices
// depends on fccp_pkg
interface fccp_req_if;
   import fccp_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [COLW-1:0]      cell_col;
   logic [COLW-1:0]      cell_row;
   logic signed [ZW-1:0] z_bottom_left;
   logic signed [ZW-1:0] z_bottom_right;
   logic signed [ZW-1:0] z_top_right;
   logic signed [ZW-1:0] z_top_left;
   logic signed [ZW-1:0] level_low;
   logic signed [ZW-1:0] level_high;
   logic                 is_top_level;
   modport source (output valid, cell_col, cell_row, z_bottom_left, z_bottom_right,
                   z_top_right, z_top_left, level_low, level_high, is_top_level,
                   input ready);
   modport sink (input valid, cell_col, cell_row, z_bottom_left, z_bottom_right,
                 z_top_right, z_top_left, level_low, level_high, is_top_level,
                 output ready);
endinterface

interface fccp_rsp_if;
   import fccp_pkg::*;
   logic                 valid;
   logic                 ready;
   logic signed [ZW-1:0] vertex_x;
   logic signed [ZW-1:0] vertex_y;
   logic                 last_vertex;
   modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
   modport sink (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

// ===== design/fccp_divider.sv =====
// fccp_divider: pipelined restoring divider, one quotient bit per stage
// depends on fccp_pkg; quotient must fit QW bits, zero divisor gives zero
module fccp_divider (
   input  logic                        clock,
   input  logic                        advance,
   input  logic [fccp_pkg::PW-1:0]     dividend,
   input  logic [fccp_pkg::ZW-1:0]     divisor,
   output logic [fccp_pkg::QW-1:0]     quotient
);
   import fccp_pkg::*;

   typedef struct packed {
      logic [ZW-1:0] rem;
      logic [QW-1:0] bits;
      logic [ZW-1:0] den;
   } div_step_type;

   function automatic div_step_type div_step(input div_step_type s);
      div_step_type r;
      logic [ZW:0] t;
      t = {s.rem, s.bits[QW-1]};
      r.den = s.den;
      if (t >= {1'b0, s.den}) begin
         r.rem  = ZW'(t - {1'b0, s.den});
         r.bits = {s.bits[QW-2:0], 1'b1};
      end else begin
         r.rem  = t[ZW-1:0];
         r.bits = {s.bits[QW-2:0], 1'b0};
      end
      return r;
   endfunction

   div_step_type stage_in;
   div_step_type stage_ff [QW];

   assign stage_in.rem  = dividend[PW-1:QW];
   assign stage_in.bits = dividend[QW-1:0];
   assign stage_in.den  = divisor;

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff[0] <= div_step(stage_in);
         for (int i = 1; i < QW; i++) begin
            stage_ff[i] <= div_step(stage_ff[i-1]);
         end
      end
   end

   assign quotient = (stage_ff[QW-1].den == '0) ? '0 : stage_ff[QW-1].bits;

endmodule

// ===== design/filled_contour_cell_polygon_unit.sv =====
// filled_contour_cell_polygon_unit: per-cell filled-contour polygon, marching squares
// depends on fccp_pkg, fccp_channels (fccp_req_if, fccp_rsp_if) and fccp_divider
//
// A cell enters on req_chan in any cycle the pipeline is not held; its three to six
// polygon vertices leave on rsp_chan one per cycle while the receiver is ready, the last
// one flagged. From accept to the first vertex a cell passes three front stages
// (differences, walk plan, products), 31 divider stages for the edge crossings, grid
// positions, then the output register. The output register holds a cell until its
// last vertex is taken, so the sustained rate is set by the result port; a cell with
// no polygon leaves without a stall. Configuration registers are read live; the user
// writes them only while nothing is in flight, which the block does not enforce.
module filled_contour_cell_polygon_unit #(
   parameter int GRID_MAX = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   fccp_req_if.sink                  req_chan,
   fccp_rsp_if.source                rsp_chan,
   input  logic                      csr_we,
   input  logic [fccp_pkg::CSRW-1:0] csr_index,
   input  logic [fccp_pkg::CFGW-1:0] csr_wdata
);
   import fccp_pkg::*;

   typedef struct packed {
      logic [COLW-1:0] col;
      logic [COLW-1:0] row;
      plan_type        plan;
   } side_type;

   function automatic logic [ZW-1:0] mag33(input logic signed [DW-1:0] v);
      logic [DW-1:0] u;
      u = v[DW-1] ? DW'(-v) : DW'(v);
      return u[ZW-1:0];
   endfunction

   // configuration
   logic [CFGW-1:0] cell_width_ff;
   logic [CFGW-1:0] cell_height_ff;
   logic [CFGW-1:0] edge_margin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_width_ff  <= CELL_WIDTH_RESET;
         cell_height_ff <= CELL_HEIGHT_RESET;
         edge_margin_ff <= EDGE_MARGIN_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_CELL_WIDTH) begin
            cell_width_ff <= csr_wdata;
         end
         if (csr_index == CSR_CELL_HEIGHT) begin
            cell_height_ff <= csr_wdata;
         end
         if (csr_index == CSR_EDGE_MARGIN) begin
            edge_margin_ff <= csr_wdata;
         end
      end
   end

   // pipeline control
   logic pipe_en;
   logic tail_done;
   logic tail_last;
   logic tail_valid_ff;
   logic accept;

   assign pipe_en        = !tail_valid_ff || tail_done;
   assign req_chan.ready = pipe_en;
   assign accept         = req_chan.valid && pipe_en;

   // stage a: differences to the level and along the edges
   logic signed [ZW-1:0] z_in [4];
   logic signed [DW-1:0] a_d_in [4];
   logic signed [DW-1:0] a_dd_in [4];
   logic                 a_keep_in;
   logic                 below_high;
   logic                 in_grid;

   assign z_in[0] = req_chan.z_bottom_left;
   assign z_in[1] = req_chan.z_bottom_right;
   assign z_in[2] = req_chan.z_top_right;
   assign z_in[3] = req_chan.z_top_left;

   always_comb begin
      below_high = req_chan.is_top_level;
      for (int k = 0; k < 4; k++) begin
         a_d_in[k] = DW'(z_in[k]) - DW'(req_chan.level_low);
         if (z_in[k] < req_chan.level_high) begin
            below_high = 1'b1;
         end
      end
      a_dd_in[0] = DW'(z_in[0]) - DW'(z_in[1]);
      a_dd_in[1] = DW'(z_in[1]) - DW'(z_in[2]);
      a_dd_in[2] = DW'(z_in[2]) - DW'(z_in[3]);
      a_dd_in[3] = DW'(z_in[3]) - DW'(z_in[0]);
      in_grid = (int'(req_chan.cell_col) < GRID_MAX - 1) &&
                (int'(req_chan.cell_row) < GRID_MAX - 1);
      a_keep_in = in_grid && below_high;
   end

   logic                 a_valid_ff;
   logic [COLW-1:0]      a_col_ff;
   logic [COLW-1:0]      a_row_ff;
   logic signed [DW-1:0] a_d_ff [4];
   logic signed [DW-1:0] a_dd_ff [4];
   logic                 a_keep_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         a_col_ff  <= req_chan.cell_col;
         a_row_ff  <= req_chan.cell_row;
         a_d_ff    <= a_d_in;
         a_dd_ff   <= a_dd_in;
         a_keep_ff <= a_keep_in;
      end
   end

   // stage b: magnitudes and vertex plan
   logic [3:0]      ge;
   logic [3:0]      pos;
   logic [ZW-1:0]   b_magd_in [4];
   logic [ZW-1:0]   b_den_in [4];
   plan_type        b_plan_in;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         ge[k]        = !a_d_ff[k][DW-1];
         pos[k]       = !a_d_ff[k][DW-1] && (a_d_ff[k] != '0);
         b_magd_in[k] = mag33(a_d_ff[k]);
         b_den_in[k]  = mag33(a_dd_ff[k]);
      end
      b_plan_in = build_plan(ge, pos, a_keep_ff);
   end

   logic            b_valid_ff;
   logic [COLW-1:0] b_col_ff;
   logic [COLW-1:0] b_row_ff;
   logic [ZW-1:0]   b_magd_ff [4];
   logic [ZW-1:0]   b_den_ff [4];
   plan_type        b_plan_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         b_col_ff  <= a_col_ff;
         b_row_ff  <= a_row_ff;
         b_magd_ff <= b_magd_in;
         b_den_ff  <= b_den_in;
         b_plan_ff <= b_plan_in;
      end
   end

   // stage c: dividends, |d| times the edge spacing
   logic [PW-1:0] c_prod_in [4];

   always_comb begin
      c_prod_in[0] = b_magd_ff[0] * cell_width_ff;
      c_prod_in[1] = b_magd_ff[1] * cell_height_ff;
      c_prod_in[2] = b_magd_ff[2] * cell_width_ff;
      c_prod_in[3] = b_magd_ff[3] * cell_height_ff;
   end

   logic            c_valid_ff;
   logic [PW-1:0]   c_prod_ff [4];
   logic [ZW-1:0]   c_den_ff [4];
   side_type        c_side_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         c_prod_ff      <= c_prod_in;
         c_den_ff       <= b_den_ff;
         c_side_ff.col  <= b_col_ff;
         c_side_ff.row  <= b_row_ff;
         c_side_ff.plan <= b_plan_ff;
      end
   end

   // crossing offsets along each edge
   logic [QW-1:0] quot [4];

   for (genvar k = 0; k < 4; k++) begin : g_div
      fccp_divider u_div (
         .clock    (clock),
         .advance  (pipe_en),
         .dividend (c_prod_ff[k]),
         .divisor  (c_den_ff[k]),
         .quotient (quot[k])
      );
   end

   logic     dv_valid_ff [QW];
   side_type dv_side_ff [QW];

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         dv_side_ff[0] <= c_side_ff;
         for (int i = 1; i < QW; i++) begin
            dv_side_ff[i] <= dv_side_ff[i-1];
         end
      end
   end

   // stage e1: grid positions
   logic            e1_valid_ff;
   logic [QW-1:0]   e1_q_ff [4];
   logic [GW-1:0]   e1_gx0_ff;
   logic [GW-1:0]   e1_gx1_ff;
   logic [GW-1:0]   e1_gy0_ff;
   logic [GW-1:0]   e1_gy1_ff;
   plan_type        e1_plan_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         e1_q_ff    <= quot;
         e1_gx0_ff  <= GW'(dv_side_ff[QW-1].col) * cell_width_ff;
         e1_gx1_ff  <= (GW'(dv_side_ff[QW-1].col) + GW'(1)) * cell_width_ff;
         e1_gy0_ff  <= GW'(dv_side_ff[QW-1].row) * cell_height_ff;
         e1_gy1_ff  <= (GW'(dv_side_ff[QW-1].row) + GW'(1)) * cell_height_ff;
         e1_plan_ff <= dv_side_ff[QW-1].plan;
      end
   end

   // stage e2: candidate vertices, held until the polygon is sent
   logic signed [VW-1:0] gx0s, gx1s, gy0s, gy1s, ms;
   logic signed [VW-1:0] qs [4];
   logic signed [ZW-1:0] cand_x_in [NCAND];
   logic signed [ZW-1:0] cand_y_in [NCAND];

   always_comb begin
      gx0s = signed'(VW'(e1_gx0_ff));
      gx1s = signed'(VW'(e1_gx1_ff));
      gy0s = signed'(VW'(e1_gy0_ff));
      gy1s = signed'(VW'(e1_gy1_ff));
      ms   = signed'(VW'(edge_margin_ff));
      for (int k = 0; k < 4; k++) begin
         qs[k] = signed'(VW'(e1_q_ff[k]));
      end
      cand_x_in[0] = sat32(gx0s - ms);     cand_y_in[0] = sat32(gy0s - ms);
      cand_x_in[1] = sat32(gx1s + ms);     cand_y_in[1] = sat32(gy0s - ms);
      cand_x_in[2] = sat32(gx1s + ms);     cand_y_in[2] = sat32(gy1s + ms);
      cand_x_in[3] = sat32(gx0s - ms);     cand_y_in[3] = sat32(gy1s + ms);
      cand_x_in[4] = sat32(gx0s + qs[0]);  cand_y_in[4] = sat32(gy0s);
      cand_x_in[5] = sat32(gx1s);          cand_y_in[5] = sat32(gy0s + qs[1]);
      cand_x_in[6] = sat32(gx1s - qs[2]);  cand_y_in[6] = sat32(gy1s);
      cand_x_in[7] = sat32(gx0s);          cand_y_in[7] = sat32(gy1s - qs[3]);
   end

   logic signed [ZW-1:0] tail_x_ff [NCAND];
   logic signed [ZW-1:0] tail_y_ff [NCAND];
   plan_type             tail_plan_ff;
   logic [CNTW-1:0]      tail_cnt_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         tail_x_ff    <= cand_x_in;
         tail_y_ff    <= cand_y_in;
         tail_plan_ff <= e1_plan_ff;
      end
   end

   // valid bits and vertex counter
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
         c_valid_ff    <= 1'b0;
         e1_valid_ff   <= 1'b0;
         tail_valid_ff <= 1'b0;
         tail_cnt_ff   <= '0;
         for (int i = 0; i < QW; i++) begin
            dv_valid_ff[i] <= 1'b0;
         end
      end else if (pipe_en) begin
         a_valid_ff     <= accept;
         b_valid_ff     <= a_valid_ff;
         c_valid_ff     <= b_valid_ff;
         dv_valid_ff[0] <= c_valid_ff;
         for (int i = 1; i < QW; i++) begin
            dv_valid_ff[i] <= dv_valid_ff[i-1];
         end
         e1_valid_ff   <= dv_valid_ff[QW-1];
         tail_valid_ff <= e1_valid_ff;
         tail_cnt_ff   <= '0;
      end else if (rsp_chan.valid && rsp_chan.ready) begin
         tail_cnt_ff <= tail_cnt_ff + CNTW'(1);
      end
   end

   // result port
   vert_ref_type    sel_ref;
   logic [SELW-1:0] sel;

   assign tail_last = (tail_cnt_ff == CNTW'(tail_plan_ff.count - CNTW'(1)));
   assign tail_done = (tail_plan_ff.count == '0) || (rsp_chan.ready && tail_last);
   assign sel_ref   = tail_plan_ff.vert[tail_cnt_ff];
   assign sel       = {sel_ref.is_cross, sel_ref.corner};

   assign rsp_chan.valid       = tail_valid_ff && (tail_plan_ff.count != '0);
   assign rsp_chan.vertex_x    = tail_x_ff[sel];
   assign rsp_chan.vertex_y    = tail_y_ff[sel];
   assign rsp_chan.last_vertex = tail_last;

   // checks
   a_cnt_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (tail_cnt_ff < tail_plan_ff.count))
      else $error("vertex counter past polygon size");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |=> (tail_valid_ff && $stable(tail_cnt_ff)
                                               && $stable(tail_plan_ff)))
      else $error("held polygon changed under stall");

   a_plan_size: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && (b_plan_ff.count != '0)) |->
         (b_plan_ff.count >= 3'd3 && b_plan_ff.count <= 3'd6))
      else $error("polygon plan with bad vertex count");

   a_c_valid_used: assert property (@(posedge clock) disable iff (reset)
      (c_valid_ff && pipe_en) |=> dv_valid_ff[0])
      else $error("item lost entering divider");

endmodule

// ===== tb/fccp_checker.sv =====
// fccp_checker: watches the cell and vertex channels, predicts each polygon and compares
// depends on fccp_pkg and fccp_channels; configuration writes are mirrored from the csr port
module fccp_checker (
   input  logic                      clock,
   input  logic                      reset,
   fccp_req_if                       req_chan,
   fccp_rsp_if                       rsp_chan,
   input  logic                      csr_we,
   input  logic [fccp_pkg::CSRW-1:0] csr_index,
   input  logic [fccp_pkg::CFGW-1:0] csr_wdata,
   output int                        fail_count,
   output int                        pending_vertices,
   output int                        vertex_total,
   output int                        polygon_total
);
   import fccp_pkg::*;

   typedef struct {
      logic signed [ZW-1:0] x;
      logic signed [ZW-1:0] y;
      logic                 last;
   } vertex_type;

   localparam int GRID_LIMIT = 1024;

   vertex_type expected_vertices[$];
   longint     width_q, height_q, margin_q;

   assign pending_vertices = expected_vertices.size();

   function automatic longint mag64(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint crossing(longint da, longint db, longint pa, longint pb);
      longint q;
      if (da == db) return pa;
      q = (mag64(da) * mag64(pb - pa)) / mag64(da - db);
      return pb >= pa ? pa + q : pa - q;
   endfunction

   function automatic logic signed [ZW-1:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   task automatic push_vertex(longint x, longint y);
      vertex_type v;
      v.x = clamp32(x);
      v.y = clamp32(y);
      v.last = 1'b0;
      expected_vertices.push_back(v);
   endtask

   task automatic predict_polygon();
      longint d[5], gx[5], gy[5], vx[5], vy[5];
      longint lo, hi, z;
      int s[5];
      int k, start, first;
      bit under_high;
      lo = longint'(req_chan.level_low);
      hi = longint'(req_chan.level_high);
      if (req_chan.cell_col >= GRID_LIMIT - 1 || req_chan.cell_row >= GRID_LIMIT - 1) return;
      start = 0;
      under_high = req_chan.is_top_level;
      for (k = 1; k <= 4; k++) begin
         case (k)
            1: z = longint'(req_chan.z_bottom_left);
            2: z = longint'(req_chan.z_bottom_right);
            3: z = longint'(req_chan.z_top_right);
            default: z = longint'(req_chan.z_top_left);
         endcase
         d[k] = z - lo;
         if (d[k] >= 0) start = k;
         if (z - hi < 0) under_high = 1'b1;
         gx[k] = longint'(req_chan.cell_col + ((k == 2 || k == 3) ? 1 : 0)) * width_q;
         gy[k] = longint'(req_chan.cell_row + ((k >= 3) ? 1 : 0)) * height_q;
         vx[k] = (k == 2 || k == 3) ? gx[k] + margin_q : gx[k] - margin_q;
         vy[k] = (k >= 3) ? gy[k] + margin_q : gy[k] - margin_q;
      end
      if (start == 0 || !under_high) return;
      polygon_total++;
      first = expected_vertices.size();
      s[1] = start;
      for (k = 2; k <= 4; k++) s[k] = s[k-1] % 4 + 1;
      push_vertex(vx[s[1]], vy[s[1]]);
      for (k = 2; k <= 4; k++) begin
         if (d[s[k]] > 0) begin
            if (k > 2 && d[s[k-1]] <= 0)
               push_vertex(crossing(d[s[k-1]], d[s[k]], gx[s[k-1]], gx[s[k]]),
                           crossing(d[s[k-1]], d[s[k]], gy[s[k-1]], gy[s[k]]));
            push_vertex(vx[s[k]], vy[s[k]]);
         end else if (d[s[k-1]] > 0 || k == 2) begin
            push_vertex(crossing(d[s[k-1]], d[s[k]], gx[s[k-1]], gx[s[k]]),
                        crossing(d[s[k-1]], d[s[k]], gy[s[k-1]], gy[s[k]]));
         end
      end
      if (d[s[4]] <= 0)
         push_vertex(crossing(d[s[4]], d[s[1]], gx[s[4]], gx[s[1]]),
                     crossing(d[s[4]], d[s[1]], gy[s[4]], gy[s[1]]));
      expected_vertices[expected_vertices.size()-1].last = 1'b1;
   endtask

   always @(posedge clock) begin
      vertex_type e;
      if (reset) begin
         width_q <= 65536;
         height_q <= 65536;
         margin_q <= 66;
         fail_count <= 0;
         vertex_total <= 0;
         polygon_total = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CELL_WIDTH:  width_q <= longint'(csr_wdata);
               CSR_CELL_HEIGHT: height_q <= longint'(csr_wdata);
               CSR_EDGE_MARGIN: margin_q <= longint'(csr_wdata);
               default: ;
            endcase
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            vertex_total <= vertex_total + 1;
            if (expected_vertices.size() == 0) begin
               $error("unexpected vertex x=%0d y=%0d", rsp_chan.vertex_x, rsp_chan.vertex_y);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_vertices.pop_front();
               if (rsp_chan.vertex_x !== e.x || rsp_chan.vertex_y !== e.y ||
                   rsp_chan.last_vertex !== e.last) begin
                  if (rsp_chan.vertex_x !== e.x)
                     $error("vertex_x expected %0d actual %0d", e.x, rsp_chan.vertex_x);
                  if (rsp_chan.vertex_y !== e.y)
                     $error("vertex_y expected %0d actual %0d", e.y, rsp_chan.vertex_y);
                  if (rsp_chan.last_vertex !== e.last)
                     $error("last_vertex expected %0d actual %0d", e.last,
                            rsp_chan.last_vertex);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) predict_polygon();
      end
   end
endmodule

// ===== tb/tb_top.sv =====
// tb_top: stimulus, configuration phases and verdict for filled_contour_cell_polygon_unit
// depends on fccp_pkg, fccp_channels, fccp_checker and the block itself
module tb_top;
   import fccp_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSRW-1:0] csr_index = CSR_CELL_WIDTH;
   logic [CFGW-1:0] csr_wdata = '0;
   int fail_count, pending_vertices, vertex_total, polygon_total;
   int cycle_count = 0;
   int cells_sent = 0;
   bit calm = 1'b0;

   fccp_req_if req_chan();
   fccp_rsp_if rsp_chan();

   filled_contour_cell_polygon_unit u_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata));

   fccp_checker u_checker (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_vertices(pending_vertices),
      .vertex_total(vertex_total), .polygon_total(polygon_total));

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("filled_contour_cell_polygon_unit verification failed");
         $finish;
      end
   end

   // receiver stalls in bursts
   initial begin
      int n;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (calm || $urandom_range(0, 3) != 0) begin
            rsp_chan.ready <= 1'b1;
            n = $urandom_range(1, 20);
         end else begin
            rsp_chan.ready <= 1'b0;
            n = $urandom_range(1, 13);
         end
         repeat (n - 1) @(posedge clock);
      end
   end

   task automatic write_reg(logic [CSRW-1:0] idx, logic [CFGW-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      while (pending_vertices != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic send_cell(logic [9:0] col, logic [9:0] row, logic signed [31:0] z1,
                            logic signed [31:0] z2, logic signed [31:0] z3,
                            logic signed [31:0] z4, logic signed [31:0] lo,
                            logic signed [31:0] hi, logic top);
      req_chan.valid <= 1'b1;
      req_chan.cell_col <= col;
      req_chan.cell_row <= row;
      req_chan.z_bottom_left <= z1;
      req_chan.z_bottom_right <= z2;
      req_chan.z_top_right <= z3;
      req_chan.z_top_left <= z4;
      req_chan.level_low <= lo;
      req_chan.level_high <= hi;
      req_chan.is_top_level <= top;
      do @(posedge clock); while (!req_chan.ready);
      cells_sent++;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   function automatic logic signed [31:0] rand_z(int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(0, 8)) * 32'sd65536 - 32'sd262144;
         default: return $signed($urandom_range(0, 65536 * 8)) - 32'sd262144;
      endcase
   endfunction

   task automatic random_cells(int count);
      int mode;
      logic signed [31:0] lo;
      repeat (count) begin
         mode = $urandom_range(0, 4);
         lo = (mode == 0) ? $urandom : $signed($urandom_range(0, 65536 * 4)) - 32'sd131072;
         send_cell($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 40),
                   $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 40),
                   rand_z(mode), rand_z(mode), rand_z(mode), rand_z(mode), lo,
                   (mode == 0) ? $urandom : lo + $signed($urandom_range(0, 65536 * 3)),
                   $urandom_range(0, 3) == 0);
      end
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.cell_col = '0;
      req_chan.cell_row = '0;
      req_chan.z_bottom_left = '0;
      req_chan.z_bottom_right = '0;
      req_chan.z_top_right = '0;
      req_chan.z_top_left = '0;
      req_chan.level_low = '0;
      req_chan.level_high = '0;
      req_chan.is_top_level = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed cells with reset spacing
      send_cell(3, 4, 65536, 65536, 65536, 65536, 0, 131072, 0);
      send_cell(3, 4, -5, -5, -5, -5, 0, 131072, 0);
      send_cell(3, 4, 200000, 200000, 200000, 200000, 0, 131072, 0);
      send_cell(3, 4, 200000, 200000, 200000, 200000, 0, 131072, 1);
      send_cell(1, 1, 65536, -65536, -65536, -65536, 0, 65536, 0);
      send_cell(1, 1, -65536, 65536, -65536, -65536, 0, 65536, 0);
      send_cell(1, 1, -65536, -65536, 65536, -65536, 0, 65536, 0);
      send_cell(1, 1, -65536, -65536, -65536, 0, 0, 65536, 0);
      send_cell(2, 2, 65536, -65536, 65536, -65536, 0, 131072, 0);
      send_cell(2, 2, -65536, 65536, -65536, 65536, 0, 131072, 0);
      send_cell(2, 2, 65536, 65536, -65536, 65536, 0, 131072, 0);
      send_cell(2, 2, 0, 0, 0, 0, 0, 65536, 0);
      send_cell(2, 2, -7, -7, 0, 0, 0, 65536, 0);
      send_cell(1022, 5, 65536, 65536, 65536, 65536, 0, 131072, 0);
      send_cell(5, 1023, 65536, 65536, 65536, 65536, 0, 131072, 0);
      send_cell(1021, 1021, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                32'sh80000000, 32'sh7fffffff, 1);
      send_cell(0, 0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                32'sh7fffffff, 32'sh80000000, 0);
      send_cell(10'h2aa, 10'h155, -1, 1, -1, 1, 0, 2, 1);
      req_chan.valid <= 1'b0;
      drain();

      // extreme spacing and margin
      write_reg(CSR_CELL_WIDTH, 31'h7fffffff);
      write_reg(CSR_CELL_HEIGHT, 31'd1);
      write_reg(CSR_EDGE_MARGIN, 31'h7fffffff);
      send_cell(1020, 0, 65536, -65536, 3, -9, 0, 65536, 0);
      send_cell(0, 1020, -65536, 65536, -3, 9, 0, 65536, 1);
      random_cells(20);
      req_chan.valid <= 1'b0;
      drain();

      write_reg(CSR_CELL_WIDTH, 31'd0);
      write_reg(CSR_CELL_HEIGHT, 31'h7fffffff);
      write_reg(CSR_EDGE_MARGIN, 31'd0);
      random_cells(30);
      req_chan.valid <= 1'b0;
      drain();

      write_reg(CSR_CELL_WIDTH, 31'd65536);
      write_reg(CSR_CELL_HEIGHT, 31'd32768);
      write_reg(CSR_EDGE_MARGIN, 31'd66);
      random_cells(30);
      calm = 1'b1;
      random_cells(30);
      req_chan.valid <= 1'b0;
      while (pending_vertices != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("sent %0d cells under four register settings", cells_sent);
      $display("checked %0d vertices in %0d polygons", vertex_total, polygon_total);
      if (fail_count == 0) begin
         $display("filled_contour_cell_polygon_unit verification clean");
      end else begin
         $display("filled_contour_cell_polygon_unit verification failed");
      end
      $finish;
   end
endmodule
